// ----- rtl/ellipsoid_surface_eval_unit_macros.svh -----
// Assertion macros shared by the RTL; empty bodies for synthesis.
`ifndef ELLIPSOID_SURFACE_EVAL_UNIT_MACROS_SVH
`define ELLIPSOID_SURFACE_EVAL_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk, off while rst_n is low
`define ESEV_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication, clocked on clk, off while rst_n is low
`define ESEV_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define ESEV_ASSERT_IMP(lbl, pre, post, msg)
`define ESEV_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

// ----- rtl/esev_pkg.sv -----
package esev_pkg;

  // Angle and fixed-point format (ANGLE_BITS must not exceed IN_ANGLE_W)
  localparam int ANGLE_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int IN_ANGLE_W   = 16;
  localparam int CORDIC_STEPS = 30;

  // Datapath widths
  localparam int AXIS_W = 24;
  localparam int OUT_W  = 48;
  localparam int TRIG_W = FRAC_BITS + 2;
  localparam int VAL_W  = FRAC_BITS + 24;
  localparam int CW     = 33;
  localparam int ZW     = 34;
  localparam int PROD_W = VAL_W + TRIG_W;

  typedef logic signed [AXIS_W-1:0] axis_t;
  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [VAL_W-1:0]  val_t;
  typedef logic signed [OUT_W-1:0]  out_val_t;

  // Register indexes
  localparam logic [1:0] REG_AXIS_A = 2'd0;
  localparam logic [1:0] REG_AXIS_B = 2'd1;
  localparam logic [1:0] REG_AXIS_C = 2'd2;

  localparam int AXIS_A_RST = 98304;
  localparam int AXIS_B_RST = 65536;
  localparam int AXIS_C_RST = 65536;

  typedef enum logic [2:0] {
    KIND_POS = 3'd0,
    KIND_DU  = 3'd1,
    KIND_DV  = 3'd2,
    KIND_NRM = 3'd3,
    KIND_DUU = 3'd4,
    KIND_DUV = 3'd5,
    KIND_DVV = 3'd6
  } kind_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic signed [ZW-1:0] atan_turn(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = ZW'(536870912);
      1:  v = ZW'(316933406);
      2:  v = ZW'(167458907);
      3:  v = ZW'(85004756);
      4:  v = ZW'(42667331);
      5:  v = ZW'(21354465);
      6:  v = ZW'(10679838);
      7:  v = ZW'(5340245);
      8:  v = ZW'(2670163);
      9:  v = ZW'(1335087);
      10: v = ZW'(667544);
      11: v = ZW'(333772);
      12: v = ZW'(166886);
      13: v = ZW'(83443);
      14: v = ZW'(41722);
      15: v = ZW'(20861);
      16: v = ZW'(10430);
      17: v = ZW'(5215);
      18: v = ZW'(2608);
      19: v = ZW'(1304);
      20: v = ZW'(652);
      21: v = ZW'(326);
      22: v = ZW'(163);
      23: v = ZW'(81);
      24: v = ZW'(41);
      25: v = ZW'(20);
      26: v = ZW'(10);
      27: v = ZW'(5);
      28: v = ZW'(3);
      29: v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // One CORDIC rotation step towards z = 0
  function automatic cordic_t cordic_step(input cordic_t s, input int i);
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cordic_t r;
    xs = s.x >>> i;
    ys = s.y >>> i;
    if (!s.z[ZW-1]) begin
      r.x = s.x - ys;
      r.y = s.y + xs;
      r.z = s.z - atan_turn(i);
    end else begin
      r.x = s.x + ys;
      r.y = s.y - xs;
      r.z = s.z + atan_turn(i);
    end
    return r;
  endfunction

  // Value times trig factor, rounded half up at FRAC_BITS
  function automatic val_t mulq(input val_t x, input trig_t t);
    logic signed [PROD_W-1:0] p;
    p = x * t;
    p = p + (PROD_W'(1) <<< (FRAC_BITS - 1));
    return val_t'(p >>> FRAC_BITS);
  endfunction

  // Product of two Q8.16 axes, rounded half up
  function automatic val_t mul_axes(input axis_t p, input axis_t q);
    logic signed [2*AXIS_W-1:0] m;
    m = p * q;
    m = m + (2*AXIS_W)'(32768);
    return val_t'(m >>> 16);
  endfunction

  // Widen to the result format; intermediate values never leave its range
  function automatic out_val_t ext_out(input val_t v);
    return {{(OUT_W-VAL_W){v[VAL_W-1]}}, v};
  endfunction

endpackage

// ----- rtl/esev_ifs.sv -----
interface esev_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] angle_u;
  logic [15:0] angle_v;
  modport source (output valid, angle_u, angle_v, input ready);
  modport sink   (input valid, angle_u, angle_v, output ready);
endinterface

interface esev_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [47:0] vec_x;
  logic [47:0] vec_y;
  logic [47:0] vec_z;
  logic        last;
  modport source (output valid, kind, vec_x, vec_y, vec_z, last, input ready);
  modport sink   (input valid, kind, vec_x, vec_y, vec_z, last, output ready);
endinterface

interface esev_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/esev_sincos.sv -----
module esev_sincos (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic [esev_pkg::IN_ANGLE_W-1:0]     angle,
  output logic                                out_valid,
  output esev_pkg::trig_t                     cos_o,
  output esev_pkg::trig_t                     sin_o
);

  localparam int NSTG = esev_pkg::CORDIC_STEPS / 2;
  localparam int SH   = 30 - esev_pkg::FRAC_BITS;

  esev_pkg::cordic_t st_r [0:NSTG];
  logic [1:0]        q_r  [0:NSTG];
  logic              v_r  [0:NSTG];

  logic [31:0] a32;
  logic [31:0] a32_off;
  logic [1:0]  q0;
  logic [31:0] d0;

  // Split the angle into quadrant and residual
  always_comb begin
    a32     = {angle[esev_pkg::ANGLE_BITS-1:0], {(32-esev_pkg::ANGLE_BITS){1'b0}}};
    a32_off = a32 + 32'h2000_0000;
    q0      = a32_off[31:30];
    d0      = a32 - {q0, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].x <= esev_pkg::CW'(652032874);
      st_r[0].y <= '0;
      st_r[0].z <= esev_pkg::ZW'($signed(d0));
      q_r[0]    <= q0;
    end
  end

  // Two rotation steps per stage
  for (genvar g = 1; g <= NSTG; g++) begin : g_stage
    esev_pkg::cordic_t s_mid;
    esev_pkg::cordic_t s_nxt;
    always_comb begin
      s_mid = esev_pkg::cordic_step(st_r[g-1], 2*g - 2);
      s_nxt = esev_pkg::cordic_step(s_mid, 2*g - 1);
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else if (en) begin
        v_r[g] <= v_r[g-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[g] <= s_nxt;
        q_r[g]  <= q_r[g-1];
      end
    end
  end

  // Round to Q.FRAC_BITS and fold the quadrant back
  logic signed [esev_pkg::CW-1:0] xr;
  logic signed [esev_pkg::CW-1:0] yr;
  esev_pkg::trig_t c_rnd;
  esev_pkg::trig_t s_rnd;
  esev_pkg::trig_t cos_nxt;
  esev_pkg::trig_t sin_nxt;
  logic            out_valid_r;
  esev_pkg::trig_t cos_r;
  esev_pkg::trig_t sin_r;

  always_comb begin
    xr    = st_r[NSTG].x + (esev_pkg::CW'(1) <<< (SH - 1));
    yr    = st_r[NSTG].y + (esev_pkg::CW'(1) <<< (SH - 1));
    c_rnd = esev_pkg::trig_t'(xr >>> SH);
    s_rnd = esev_pkg::trig_t'(yr >>> SH);
    case (q_r[NSTG])
      2'd0:    begin cos_nxt = c_rnd;  sin_nxt = s_rnd;  end
      2'd1:    begin cos_nxt = -s_rnd; sin_nxt = c_rnd;  end
      2'd2:    begin cos_nxt = -c_rnd; sin_nxt = -s_rnd; end
      default: begin cos_nxt = s_rnd;  sin_nxt = -c_rnd; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cos_o     = cos_r;
  assign sin_o     = sin_r;

endmodule

// ----- rtl/ellipsoid_surface_eval_unit.sv -----
// The result channel moves one 3-vector word per cycle while out_ch.ready is
// high; the datapath takes no new (u, v) word while its last stage is still
// emitting the results of the word before.
// Reset: synchronous, active low; clears all valid bits and loads the axes
// with a = 1.5, b = 1.0, c = 1.0.
`include "ellipsoid_surface_eval_unit_macros.svh"

module ellipsoid_surface_eval_unit (
  input  logic       clk,
  input  logic       rst_n,
  esev_in_if.sink    in_ch,
  esev_out_if.source out_ch,
  esev_cfg_if.sink   cfg_ch
);

  // Axis registers
  esev_pkg::axis_t axis_a_r, axis_b_r, axis_c_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_a_r <= esev_pkg::axis_t'(esev_pkg::AXIS_A_RST);
      axis_b_r <= esev_pkg::axis_t'(esev_pkg::AXIS_B_RST);
      axis_c_r <= esev_pkg::axis_t'(esev_pkg::AXIS_C_RST);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        esev_pkg::REG_AXIS_A: axis_a_r <= cfg_ch.data;
        esev_pkg::REG_AXIS_B: axis_b_r <= cfg_ch.data;
        esev_pkg::REG_AXIS_C: axis_c_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Global advance: the pipeline moves unless its last stage is still emitting
  logic ce;
  logic v3_r;
  logic load;
  esev_pkg::kind_t k_r;

  assign ce          = !v3_r || (load && (k_r == esev_pkg::KIND_DVV));
  assign in_ch.ready = ce;

  // Sine and cosine of both angles
  logic            vu, vv;
  esev_pkg::trig_t cu, su, cv, sv;

  esev_sincos u_sc_u (
    .clk(clk), .rst_n(rst_n), .en(ce), .in_valid(in_ch.valid),
    .angle(in_ch.angle_u), .out_valid(vu), .cos_o(cu), .sin_o(su)
  );

  esev_sincos u_sc_v (
    .clk(clk), .rst_n(rst_n), .en(ce), .in_valid(in_ch.valid),
    .angle(in_ch.angle_v), .out_valid(vv), .cos_o(cv), .sin_o(sv)
  );

  // First products: axis times trig, sin^2 v, axis pairs
  logic v1_r;
  esev_pkg::val_t  acu_r, asu_r, bsu_r, bcu_r, ccv_r, csv_r, ab_r, ac_r, bc_r;
  esev_pkg::trig_t s2v_r, cu1_r, su1_r, cv1_r, sv1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= vu & vv;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      acu_r <= esev_pkg::mulq(esev_pkg::val_t'(axis_a_r), cu);
      asu_r <= esev_pkg::mulq(esev_pkg::val_t'(axis_a_r), su);
      bsu_r <= esev_pkg::mulq(esev_pkg::val_t'(axis_b_r), su);
      bcu_r <= esev_pkg::mulq(esev_pkg::val_t'(axis_b_r), cu);
      ccv_r <= esev_pkg::mulq(esev_pkg::val_t'(axis_c_r), cv);
      csv_r <= esev_pkg::mulq(esev_pkg::val_t'(axis_c_r), sv);
      s2v_r <= esev_pkg::trig_t'(esev_pkg::mulq(esev_pkg::val_t'(sv), sv));
      ab_r  <= esev_pkg::mul_axes(axis_a_r, axis_b_r);
      ac_r  <= esev_pkg::mul_axes(axis_a_r, axis_c_r);
      bc_r  <= esev_pkg::mul_axes(axis_b_r, axis_c_r);
      cu1_r <= cu;
      su1_r <= su;
      cv1_r <= cv;
      sv1_r <= sv;
    end
  end

  // Second products
  logic v2_r;
  esev_pkg::val_t  px2_r, py2_r, pz2_r, dux2_r, duy2_r, dvx2_r, dvy2_r, dvz2_r;
  esev_pkg::val_t  duvx2_r, duvy2_r, t1_r, t2_r, t3_r;
  esev_pkg::trig_t cu2_r, su2_r, cv2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ce) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      px2_r   <= esev_pkg::mulq(acu_r, sv1_r);
      py2_r   <= esev_pkg::mulq(bsu_r, sv1_r);
      pz2_r   <= ccv_r;
      dux2_r  <= -esev_pkg::mulq(asu_r, sv1_r);
      duy2_r  <= esev_pkg::mulq(bcu_r, sv1_r);
      dvx2_r  <= esev_pkg::mulq(acu_r, cv1_r);
      dvy2_r  <= esev_pkg::mulq(bsu_r, cv1_r);
      dvz2_r  <= -csv_r;
      duvx2_r <= -esev_pkg::mulq(asu_r, cv1_r);
      duvy2_r <= esev_pkg::mulq(bcu_r, cv1_r);
      t1_r    <= esev_pkg::mulq(bc_r, s2v_r);
      t2_r    <= esev_pkg::mulq(ac_r, s2v_r);
      t3_r    <= esev_pkg::mulq(ab_r, sv1_r);
      cu2_r   <= cu1_r;
      su2_r   <= su1_r;
      cv2_r   <= cv1_r;
    end
  end

  // Third products: the normal; carry the rest alongside
  esev_pkg::val_t px_r, py_r, pz_r, dux_r, duy_r, dvx_r, dvy_r, dvz_r;
  esev_pkg::val_t duvx_r, duvy_r, nx_r, ny_r, nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ce) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      px_r   <= px2_r;
      py_r   <= py2_r;
      pz_r   <= pz2_r;
      dux_r  <= dux2_r;
      duy_r  <= duy2_r;
      dvx_r  <= dvx2_r;
      dvy_r  <= dvy2_r;
      dvz_r  <= dvz2_r;
      duvx_r <= duvx2_r;
      duvy_r <= duvy2_r;
      nx_r   <= -esev_pkg::mulq(t1_r, cu2_r);
      ny_r   <= -esev_pkg::mulq(t2_r, su2_r);
      nz_r   <= -esev_pkg::mulq(t3_r, cv2_r);
    end
  end

  // Pick the vector for the current kind
  esev_pkg::val_t sel_x, sel_y, sel_z;

  always_comb begin
    case (k_r)
      esev_pkg::KIND_POS: begin sel_x = px_r;   sel_y = py_r;   sel_z = pz_r;  end
      esev_pkg::KIND_DU:  begin sel_x = dux_r;  sel_y = duy_r;  sel_z = '0;    end
      esev_pkg::KIND_DV:  begin sel_x = dvx_r;  sel_y = dvy_r;  sel_z = dvz_r; end
      esev_pkg::KIND_NRM: begin sel_x = nx_r;   sel_y = ny_r;   sel_z = nz_r;  end
      esev_pkg::KIND_DUU: begin sel_x = -px_r;  sel_y = -py_r;  sel_z = '0;    end
      esev_pkg::KIND_DUV: begin sel_x = duvx_r; sel_y = duvy_r; sel_z = '0;    end
      default:            begin sel_x = -px_r;  sel_y = -py_r;  sel_z = -pz_r; end
    endcase
  end

  // Output register: load the next vector whenever it is free or being taken
  logic              out_valid_r;
  esev_pkg::kind_t   out_kind_r;
  logic              out_last_r;
  esev_pkg::out_val_t out_x_r, out_y_r, out_z_r;
  logic              out_fire;

  assign out_fire = out_valid_r && out_ch.ready;
  assign load     = v3_r && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= esev_pkg::KIND_POS;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        k_r <= (k_r == esev_pkg::KIND_DVV) ? esev_pkg::KIND_POS
                                            : esev_pkg::kind_t'(k_r + 3'd1);
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r <= k_r;
      out_last_r <= (k_r == esev_pkg::KIND_DVV);
      out_x_r    <= esev_pkg::ext_out(sel_x);
      out_y_r    <= esev_pkg::ext_out(sel_y);
      out_z_r    <= esev_pkg::ext_out(sel_z);
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.last  = out_last_r;
  assign out_ch.vec_x = out_x_r;
  assign out_ch.vec_y = out_y_r;
  assign out_ch.vec_z = out_z_r;

  // Checks
  `ESEV_ASSERT_NXT(a_kind_follows, out_fire && (out_kind_r != esev_pkg::KIND_DVV), out_valid_r && (out_kind_r == esev_pkg::kind_t'($past(out_kind_r) + 3'd1)), "result kinds out of order")
  `ESEV_ASSERT_NXT(a_run_restarts, out_fire && (out_kind_r == esev_pkg::KIND_DVV), !out_valid_r || (out_kind_r == esev_pkg::KIND_POS), "run does not restart at position")
  `ESEV_ASSERT_IMP(a_stall_full, !ce, v3_r, "pipeline stalled with empty last stage")

endmodule
